// ===== hw/rtl/gdd_pkg.sv =====
`timescale 1ns / 1ps

package gdd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DAYNUM_W = 23;
  localparam int DIST_W   = 22;
  localparam int Q100_W   = 8;
  localparam int R100_W   = 7;

  // floor(p / 100) == (p * 10486) >> 20 for every p below 2**14
  localparam logic [YEAR_W-1:0] DIV100_MUL   = 14'd10486;
  localparam int                DIV100_SHIFT = 20;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic                valid;
    logic [DAYNUM_W-1:0] daynum;
  } date_info_t;

  // Length of a month; zero for a code that is no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/gregorian_date_difference_core.sv =====
`timescale 1ns / 1ps

// Gregorian day distance.
// Input channel (in_valid/in_ready) carries two dates, each as day, month and
// year. Output channel (out_valid/out_ready) returns the absolute distance in
// days between them with one validity flag per date; the distance reads 0
// when either date is invalid (year 0 or above MAX_YEAR, bad month, or a day
// that does not fit the month).
// A transfer accepted on the input shows on the output once it has passed
// four register stages (year arithmetic, leap rule and validity, day number,
// distance), which advance together.
// Throughput: one date pair per cycle while the output is not stalled.
// When the receiver holds out_ready low while out_valid is high the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline; no result is pending after.
module gregorian_date_difference_core #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gdd_pkg::DAY_W-1:0]            day_a,
  input  logic [gdd_pkg::MONTH_W-1:0]          month_a,
  input  logic [gdd_pkg::YEAR_W-1:0]           year_a,
  input  logic [gdd_pkg::DAY_W-1:0]            day_b,
  input  logic [gdd_pkg::MONTH_W-1:0]          month_b,
  input  logic [gdd_pkg::YEAR_W-1:0]           year_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gdd_pkg::DIST_W-1:0]           day_distance,
  output logic                                 first_valid,
  output logic                                 second_valid
);

  logic [3:0]          vld;
  logic                en;
  gdd_pkg::date_info_t info_a;
  gdd_pkg::date_info_t info_b;

  assign en        = !vld[3] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  gdd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv_a (
    .clk   (clk),
    .en    (en),
    .day   (day_a),
    .month (month_a),
    .year  (year_a),
    .info  (info_a)
  );

  gdd_date_conv #(.MAX_YEAR(MAX_YEAR)) u_conv_b (
    .clk   (clk),
    .en    (en),
    .day   (day_b),
    .month (month_b),
    .year  (year_b),
    .info  (info_b)
  );

  logic [gdd_pkg::DAYNUM_W-1:0] diff;
  logic [gdd_pkg::DIST_W-1:0]   span_days;

  assign diff = (info_a.daynum > info_b.daynum) ? (info_a.daynum - info_b.daynum)
                                                : (info_b.daynum - info_a.daynum);
  assign span_days = (info_a.valid && info_b.valid) ? diff[gdd_pkg::DIST_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      day_distance <= span_days;
      first_valid  <= info_a.valid;
      second_valid <= info_b.valid;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (!first_valid || !second_valid)) |-> (day_distance == '0))
    else $error("distance not zero for an invalid date");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted transfer did not enter the first stage");

  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[2]))
    else $error("result appeared without passing the third stage");
`endif

endmodule

// ===== hw/rtl/gdd_date_conv.sv =====
`timescale 1ns / 1ps

module gdd_date_conv #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [gdd_pkg::DAY_W-1:0]    day,
  input  logic [gdd_pkg::MONTH_W-1:0]  month,
  input  logic [gdd_pkg::YEAR_W-1:0]   year,
  output gdd_pkg::date_info_t          info
);

  localparam logic [16:0] MaxYear = 17'(MAX_YEAR);
  localparam int          ProdW   = 2 * gdd_pkg::YEAR_W;

  // stage 1: elapsed years, (year - 1)/100 by reciprocal, years * 365
  logic [gdd_pkg::YEAR_W-1:0]   p;
  logic [ProdW-1:0]             prod100;
  logic [gdd_pkg::DAYNUM_W-1:0] p365;

  logic [gdd_pkg::YEAR_W-1:0]   s1_p;
  logic [gdd_pkg::Q100_W-1:0]   s1_q100;
  logic [gdd_pkg::DAYNUM_W-1:0] s1_p365;
  logic [gdd_pkg::DAY_W-1:0]    s1_day;
  logic [gdd_pkg::MONTH_W-1:0]  s1_month;
  logic                         s1_div4;
  logic                         s1_yok;

  assign p       = year - 14'd1;
  assign prod100 = ProdW'(p) * ProdW'(gdd_pkg::DIV100_MUL);
  assign p365    = gdd_pkg::DAYNUM_W'(p) * 23'd365;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p     <= p;
      s1_q100  <= prod100[gdd_pkg::DIV100_SHIFT +: gdd_pkg::Q100_W];
      s1_p365  <= p365;
      s1_day   <= day;
      s1_month <= month;
      s1_div4  <= (year[1:0] == 2'b00);
      s1_yok   <= (year != '0) && (17'(year) <= MaxYear);
    end
  end

  // stage 2: leap rule, validity, days up to the start of the year
  logic [gdd_pkg::YEAR_W-1:0]   q_times;
  logic [gdd_pkg::YEAR_W-1:0]   rem_full;
  logic [gdd_pkg::R100_W-1:0]   r100;
  logic                         leap;
  logic [gdd_pkg::DAY_W-1:0]    mlen;
  logic                         valid;
  logic [gdd_pkg::DAYNUM_W-1:0] ydays;

  logic [gdd_pkg::DAYNUM_W-1:0] s2_ydays;
  logic [gdd_pkg::DAY_W-1:0]    s2_day;
  logic [gdd_pkg::MONTH_W-1:0]  s2_month;
  logic                         s2_leap;
  logic                         s2_valid;

  assign q_times  = gdd_pkg::YEAR_W'(s1_q100) * 14'd100;
  assign rem_full = s1_p - q_times;
  assign r100     = rem_full[gdd_pkg::R100_W-1:0];
  // year divisible by 100 <=> (year - 1) mod 100 == 99; by 400 adds (year - 1) / 100 mod 4 == 3
  assign leap     = (s1_div4 && (r100 != 7'd99)) ||
                    ((r100 == 7'd99) && (s1_q100[1:0] == 2'b11));
  assign mlen     = gdd_pkg::month_len(s1_month, leap);
  assign valid    = s1_yok && (s1_month >= gdd_pkg::MONTH_JAN) &&
                    (s1_month <= gdd_pkg::MONTH_DEC) &&
                    (s1_day != '0) && (s1_day <= mlen);
  assign ydays    = s1_p365 + gdd_pkg::DAYNUM_W'(s1_p[gdd_pkg::YEAR_W-1:2])
                    - gdd_pkg::DAYNUM_W'(s1_q100)
                    + gdd_pkg::DAYNUM_W'(s1_q100[gdd_pkg::Q100_W-1:2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ydays <= ydays;
      s2_day   <= s1_day;
      s2_month <= s1_month;
      s2_leap  <= leap;
      s2_valid <= valid;
    end
  end

  // stage 3: add month offset, day and leap day
  logic                         late_leap;
  logic [gdd_pkg::DAYNUM_W-1:0] dnum;

  assign late_leap = s2_leap && (s2_month > gdd_pkg::MONTH_FEB);
  assign dnum      = s2_ydays + gdd_pkg::DAYNUM_W'(gdd_pkg::days_before(s2_month))
                     + gdd_pkg::DAYNUM_W'(s2_day) + gdd_pkg::DAYNUM_W'(late_leap);

  always_ff @(posedge clk) begin
    if (en) begin
      info.valid  <= s2_valid;
      info.daynum <= dnum;
    end
  end

endmodule
